FILE: src/saitlb_pkg.sv
// ============================================================================
// saitlb_pkg
// Shared types and constants of the set-associative instruction TLB.
// ============================================================================
`default_nettype none

package saitlb_pkg;

  // request opcodes
  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_PEEK      = 3'd1;
  localparam logic [2:0] OP_WR_MATCH  = 3'd2;
  localparam logic [2:0] OP_WR_TRANS  = 3'd3;
  localparam logic [2:0] OP_RD_MATCH  = 3'd4;
  localparam logic [2:0] OP_RD_TRANS  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MMU_PRESENT = 3'd0;
  localparam logic [2:0] CFG_WAYS_IN_USE = 3'd1;
  localparam logic [2:0] CFG_SETS_LOG2   = 3'd2;
  localparam logic [2:0] CFG_PAGE_LOG2   = 3'd3;
  localparam logic [2:0] CFG_LRU_REFRESH = 3'd4;

  // match word layout
  localparam int MR_VALID_BIT = 0;
  localparam int MR_LRU_HI    = 7;
  localparam int MR_LRU_LO    = 6;

  // translate word layout
  localparam int          TR_CI_BIT   = 1;
  localparam int          TR_UXE_BIT  = 6;
  localparam int          TR_SXE_BIT  = 7;
  localparam logic [31:0] TR_PPN_MASK = 32'hFFFF_E000;

  // bypass fetches at or above this address are cache inhibited
  localparam logic [31:0] BYPASS_CI_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic       mmu_present;
    logic [2:0] ways_in_use;
    logic [2:0] sets_log2;
    logic [4:0] page_log2;
    logic [1:0] lru_refresh;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] virt_addr;
    logic        mmu_on;
    logic        supervisor;
    logic [1:0]  way_sel;
    logic [5:0]  set_sel;
    logic [31:0] write_word;
  } req_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic [1:0]  status;
    logic        cache_inhibit;
    logic [31:0] read_word;
  } res_t;

  // row write-back enables
  typedef struct packed {
    logic match_we;
    logic trans_we;
  } wb_t;

endpackage

`default_nettype wire

FILE: src/saitlb_ram.sv
// ============================================================================
// saitlb_ram
// Row memory: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module saitlb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/saitlb_lookup.sv
// ============================================================================
// saitlb_lookup
// Way compare, result formation and row update for one request.
// ============================================================================
`default_nettype none

module saitlb_lookup import saitlb_pkg::*; #(
  parameter int MAX_WAYS = 4
) (
  input  wire req_t                  req,
  input  wire logic                  set_ok,
  input  wire cfg_t                  cfg,
  input  wire logic [MAX_WAYS-1:0][31:0] match_row,
  input  wire logic [MAX_WAYS-1:0][31:0] trans_row,
  output logic      [MAX_WAYS-1:0][31:0] match_row_nxt,
  output logic      [MAX_WAYS-1:0][31:0] trans_row_nxt,
  output wb_t                        wb,
  output res_t                       res
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [2:0]          nways;
  logic [5:0]          vsh;
  logic [31:0]         vmask;
  logic [31:0]         omask;
  logic [MAX_WAYS-1:0] hit_vec;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic [31:0]         tw;
  logic [31:0]         addr;
  logic                allowed;
  logic                bypass;
  logic                reg_ok;
  logic [WAY_W-1:0]    way_idx;

  assign nways  = (cfg.ways_in_use > 3'(MAX_WAYS)) ? 3'(MAX_WAYS) : cfg.ways_in_use;
  assign vsh    = {1'b0, cfg.page_log2} + {3'b000, cfg.sets_log2};
  assign vmask  = (vsh >= 6'd32) ? 32'h0 : (32'hFFFF_FFFF << vsh[4:0]);
  assign omask  = ~(32'hFFFF_FFFF << cfg.page_log2);
  assign bypass = !cfg.mmu_present || !req.mmu_on;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w] = set_ok && (3'(w) < nways) && match_row[w][MR_VALID_BIT] &&
                   ((match_row[w] & vmask) == (req.virt_addr & vmask));
    end
  end

  // lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign tw      = trans_row[hit_way];
  assign allowed = req.supervisor ? tw[TR_SXE_BIT] : tw[TR_UXE_BIT];
  assign addr    = (tw & TR_PPN_MASK) | (req.virt_addr & omask);
  assign reg_ok  = set_ok && ({1'b0, req.way_sel} < 3'(MAX_WAYS));
  assign way_idx = req.way_sel[WAY_W-1:0];

  always_comb begin
    logic [1:0] lru;
    lru           = 2'd0;
    res           = '0;
    wb            = '0;
    match_row_nxt = match_row;
    trans_row_nxt = trans_row;
    unique case (req.opcode) inside
      OP_TRANSLATE, OP_PEEK: begin
        if (bypass) begin
          res.phys_addr     = req.virt_addr;
          res.cache_inhibit = (req.virt_addr >= BYPASS_CI_LIMIT);
        end else if (!hit) begin
          res.status = ST_MISS;
        end else if (req.opcode == OP_TRANSLATE) begin
          // age every searched way, then refresh the hit way
          for (int w = 0; w < MAX_WAYS; w++) begin
            if (3'(w) < nways) begin
              lru = match_row[w][MR_LRU_HI:MR_LRU_LO];
              if (lru != 2'd0) begin
                match_row_nxt[w][MR_LRU_HI:MR_LRU_LO] = lru - 2'd1;
              end
            end
          end
          match_row_nxt[hit_way][MR_LRU_HI:MR_LRU_LO] =
            match_row_nxt[hit_way][MR_LRU_HI:MR_LRU_LO] | cfg.lru_refresh;
          wb.match_we       = 1'b1;
          res.phys_addr     = addr;
          res.cache_inhibit = tw[TR_CI_BIT];
          res.status        = allowed ? ST_OK : ST_FAULT;
        end else if (allowed) begin
          res.phys_addr     = addr;
          res.cache_inhibit = tw[TR_CI_BIT];
        end else begin
          res.status = ST_FAULT;
        end
      end
      OP_WR_MATCH: begin
        if (reg_ok) begin
          match_row_nxt[way_idx] = req.write_word;
          wb.match_we            = 1'b1;
        end
      end
      OP_WR_TRANS: begin
        if (reg_ok) begin
          trans_row_nxt[way_idx] = req.write_word;
          wb.trans_we            = 1'b1;
        end
      end
      OP_RD_MATCH: begin
        if (reg_ok) begin
          res.read_word = match_row[way_idx];
        end
      end
      OP_RD_TRANS: begin
        if (reg_ok) begin
          res.read_word = trans_row[way_idx];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/set_assoc_itlb_translate_core.sv
// ============================================================================
// set_assoc_itlb_translate_core
// Set-associative instruction TLB with translate, peek and entry access.
// ============================================================================
// For each request, the accepting edge starts a read of one whole set (all
// ways) from the match and translate row memories, and the next cycle
// compares the ways, forms the result and writes the updated row back, so
// no new request is taken until that compare cycle ends. The read and
// compare steps come from the registered read data of the row memories
// plus the read-modify-write of the LRU fields. Results sit in an output
// register, so the next request is accepted while a finished result waits
// to be taken; the compare cycle waits only if that register is still full.
// After reset a clearing pass zeroes every row (all entries invalid); no
// request is accepted during it, configuration writes are taken always.
// Configuration registers must only be written while no request is pending.
// ============================================================================
`default_nettype none

module set_assoc_itlb_translate_core import saitlb_pkg::*; #(
  parameter int SETS     = 64,
  parameter int MAX_WAYS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [31:0] in_virt_addr,
  input  wire logic        in_mmu_on,
  input  wire logic        in_supervisor,
  input  wire logic [1:0]  in_way_sel,
  input  wire logic [5:0]  in_set_sel,
  input  wire logic [31:0] in_write_word,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_phys_addr,
  output logic      [1:0]  out_status,
  output logic             out_cache_inhibit,
  output logic      [31:0] out_read_word,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_wdata
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W = MAX_WAYS * 32;

  // control states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r;
  cfg_t             cfg_r;
  req_t             req_r;
  logic             set_ok_r;
  logic [SET_W-1:0] row_r;
  logic             out_valid_r;
  res_t             res_r;

  logic             accept;
  logic             exec_go;
  logic             lookup_op;
  logic [6:0]       look_set;
  logic [6:0]       row_sel;
  logic             set_ok_in;

  logic [MAX_WAYS-1:0][31:0] match_row, trans_row;
  logic [MAX_WAYS-1:0][31:0] match_row_nxt, trans_row_nxt;
  logic [ROW_W-1:0]          match_wdata, trans_wdata;
  logic                      match_we, trans_we;
  logic [SET_W-1:0]          waddr;
  wb_t                       wb;
  res_t                      res;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result register must be free (or emptying) before the compare cycle ends
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // --- row select at accept time -------------------------------------------
  // translate/peek: set from the bits above the page offset, masked to the
  // sets in use; register ops: the addressed set
  assign lookup_op = (in_opcode == OP_TRANSLATE) || (in_opcode == OP_PEEK);
  assign look_set  = 7'(in_virt_addr >> cfg_r.page_log2) & ~(7'h7F << cfg_r.sets_log2);
  assign row_sel   = lookup_op ? look_set : {1'b0, in_set_sel};
  assign set_ok_in = ({1'b0, row_sel} < 8'(SETS));

  // --- configuration registers ---------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mmu_present <= 1'b1;
      cfg_r.ways_in_use <= 3'd1;
      cfg_r.sets_log2   <= 3'd6;
      cfg_r.page_log2   <= 5'd13;
      cfg_r.lru_refresh <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MMU_PRESENT: cfg_r.mmu_present <= cfg_wdata[0];
        CFG_WAYS_IN_USE: cfg_r.ways_in_use <= cfg_wdata[2:0];
        CFG_SETS_LOG2:   cfg_r.sets_log2   <= cfg_wdata[2:0];
        CFG_PAGE_LOG2:   cfg_r.page_log2   <= cfg_wdata[4:0];
        CFG_LRU_REFRESH: cfg_r.lru_refresh <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // --- sequencer -------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == SET_W'(SETS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
    end
  end

  // request payload held for the compare cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= '{opcode:     in_opcode,
                    virt_addr:  in_virt_addr,
                    mmu_on:     in_mmu_on,
                    supervisor: in_supervisor,
                    way_sel:    in_way_sel,
                    set_sel:    in_set_sel,
                    write_word: in_write_word};
      set_ok_r <= set_ok_in;
      row_r    <= row_sel[SET_W-1:0];
    end
  end

  // --- row memories ----------------------------------------------------------
  // Write-back lands at the end of the compare cycle; the next read starts at
  // a later accept edge, so a read never overlaps a write to the same row.
  assign match_we    = (state_r == S_CLEAR) || (exec_go && wb.match_we);
  assign trans_we    = (state_r == S_CLEAR) || (exec_go && wb.trans_we);
  assign waddr       = (state_r == S_CLEAR) ? clr_cnt_r : row_r;
  assign match_wdata = (state_r == S_CLEAR) ? '0 : ROW_W'(match_row_nxt);
  assign trans_wdata = (state_r == S_CLEAR) ? '0 : ROW_W'(trans_row_nxt);

  saitlb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_match_ram (
    .clk   (clk),
    .we    (match_we),
    .waddr (waddr),
    .wdata (match_wdata),
    .re    (accept),
    .raddr (row_sel[SET_W-1:0]),
    .rdata (match_row)
  );

  saitlb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr (waddr),
    .wdata (trans_wdata),
    .re    (accept),
    .raddr (row_sel[SET_W-1:0]),
    .rdata (trans_row)
  );

  // --- compare / update ------------------------------------------------------
  saitlb_lookup #(
    .MAX_WAYS (MAX_WAYS)
  ) u_lookup (
    .req           (req_r),
    .set_ok        (set_ok_r),
    .cfg           (cfg_r),
    .match_row     (match_row),
    .trans_row     (trans_row),
    .match_row_nxt (match_row_nxt),
    .trans_row_nxt (trans_row_nxt),
    .wb            (wb),
    .res           (res)
  );

  // --- result register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_phys_addr     = res_r.phys_addr;
  assign out_status        = res_r.status;
  assign out_cache_inhibit = res_r.cache_inhibit;
  assign out_read_word     = res_r.read_word;

  // --- assertions ------------------------------------------------------------
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without a compare cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(match_we || trans_we))
    else $error("row write while idle");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status == ST_MISS)) |->
      ((res_r.phys_addr == 32'h0) && !res_r.cache_inhibit))
    else $error("miss result carries an address");

endmodule

`default_nettype wire

FILE: tb/itlb_shadow_check.sv
// ============================================================================
// itlb_shadow_check
// Watches the request, result and configuration ports of the instruction
// TLB, keeps a shadow copy of the match/translate stores and the settings,
// works out each result as the request is taken and compares it, field by
// field, with what the block returns, in order.
// ============================================================================

module itlb_shadow_check import saitlb_pkg::*; #(
  parameter int SETS     = 64,
  parameter int MAX_WAYS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_virt_addr,
  input  logic        in_mmu_on,
  input  logic        in_supervisor,
  input  logic [1:0]  in_way_sel,
  input  logic [5:0]  in_set_sel,
  input  logic [31:0] in_write_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_phys_addr,
  input  logic [1:0]  out_status,
  input  logic        out_cache_inhibit,
  input  logic [31:0] out_read_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          hit_count,
  output int          miss_count,
  output int          fault_count,
  output int          bypass_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   DEPTH        = MAX_WAYS * SETS;
  localparam cfg_t CFG_AT_RESET = '{1'b1, 3'd1, 3'd6, 5'd13, 2'd3};

  logic [31:0] shadow_match [DEPTH];
  logic [31:0] shadow_trans [DEPTH];
  cfg_t        shadow_cfg;
  res_t        xlate_due [$];
  res_t        got, want;
  req_t        rq;
  int          n_fail, n_hit, n_miss, n_fault, n_bypass;

  // Applies one request to the shadow state and returns its result.
  function automatic res_t model_access(input req_t r);
    res_t        rs;
    logic [31:0] set_ix, vmask, omask, tw, addr;
    logic [63:0] wide;
    int          p, s, nways, hit, w, idx;
    logic        permit;
    rs  = '0;
    hit = -1;
    p   = shadow_cfg.page_log2;
    s   = shadow_cfg.sets_log2;
    idx = r.way_sel * SETS + r.set_sel;
    case (r.opcode)
      OP_TRANSLATE, OP_PEEK: begin
        if (!shadow_cfg.mmu_present || !r.mmu_on) begin
          rs.phys_addr     = r.virt_addr;
          rs.cache_inhibit = (r.virt_addr >= BYPASS_CI_LIMIT);
          n_bypass++;
        end else begin
          set_ix = (r.virt_addr >> p) & ((32'd1 << s) - 32'd1);
          wide   = ~((64'd1 << (p + s)) - 64'd1);
          vmask  = wide[31:0];
          wide   = (64'd1 << p) - 64'd1;
          omask  = wide[31:0];
          nways  = (shadow_cfg.ways_in_use > MAX_WAYS) ? MAX_WAYS : shadow_cfg.ways_in_use;
          if (set_ix < SETS) begin
            for (w = 0; w < nways && hit < 0; w++) begin
              idx = w * SETS + set_ix;
              if (shadow_match[idx][MR_VALID_BIT] &&
                  ((shadow_match[idx] & vmask) == (r.virt_addr & vmask)))
                hit = idx;
            end
          end
          if (hit < 0) begin
            rs.status = ST_MISS;
            n_miss++;
          end else begin
            tw     = shadow_trans[hit];
            permit = r.supervisor ? tw[TR_SXE_BIT] : tw[TR_UXE_BIT];
            addr   = (tw & TR_PPN_MASK) | (r.virt_addr & omask);
            if (r.opcode == OP_TRANSLATE) begin
              // age every searched way, then refresh the hit way
              for (w = 0; w < nways; w++) begin
                idx = w * SETS + set_ix;
                if (shadow_match[idx][MR_LRU_HI:MR_LRU_LO] != 2'd0)
                  shadow_match[idx][MR_LRU_HI:MR_LRU_LO] =
                    shadow_match[idx][MR_LRU_HI:MR_LRU_LO] - 2'd1;
              end
              shadow_match[hit][MR_LRU_HI:MR_LRU_LO] |= shadow_cfg.lru_refresh;
              rs.phys_addr     = addr;
              rs.cache_inhibit = tw[TR_CI_BIT];
              rs.status        = permit ? ST_OK : ST_FAULT;
            end else if (permit) begin
              rs.phys_addr     = addr;
              rs.cache_inhibit = tw[TR_CI_BIT];
            end else begin
              rs.status = ST_FAULT;
            end
            if (permit) n_hit++;
            else n_fault++;
          end
        end
      end
      OP_WR_MATCH: if (r.way_sel < MAX_WAYS && r.set_sel < SETS) shadow_match[idx] = r.write_word;
      OP_WR_TRANS: if (r.way_sel < MAX_WAYS && r.set_sel < SETS) shadow_trans[idx] = r.write_word;
      OP_RD_MATCH: if (r.way_sel < MAX_WAYS && r.set_sel < SETS) rs.read_word = shadow_match[idx];
      OP_RD_TRANS: if (r.way_sel < MAX_WAYS && r.set_sel < SETS) rs.read_word = shadow_trans[idx];
      default: ;
    endcase
    return rs;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        shadow_match[i] = '0;
        shadow_trans[i] = '0;
      end
      shadow_cfg = CFG_AT_RESET;
      xlate_due.delete();
      n_fail   = 0;
      n_hit    = 0;
      n_miss   = 0;
      n_fault  = 0;
      n_bypass = 0;
    end else begin
      // results never leave on the edge that takes their request, so pop first
      if (out_valid && out_ready) begin
        got = '{out_phys_addr, out_status, out_cache_inhibit, out_read_word};
        if (xlate_due.size() == 0) begin
          $error("result taken with no request outstanding");
          n_fail++;
        end else begin
          want = xlate_due.pop_front();
          check_field("phys_addr", want.phys_addr, got.phys_addr);
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("cache_inhibit", 32'(want.cache_inhibit), 32'(got.cache_inhibit));
          check_field("read_word", want.read_word, got.read_word);
        end
      end
      if (in_valid && in_ready) begin
        rq = '{in_opcode, in_virt_addr, in_mmu_on, in_supervisor,
               in_way_sel, in_set_sel, in_write_word};
        xlate_due.push_back(model_access(rq));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MMU_PRESENT: shadow_cfg.mmu_present = cfg_wdata[0];
          CFG_WAYS_IN_USE: shadow_cfg.ways_in_use = cfg_wdata[2:0];
          CFG_SETS_LOG2:   shadow_cfg.sets_log2   = cfg_wdata[2:0];
          CFG_PAGE_LOG2:   shadow_cfg.page_log2   = cfg_wdata[4:0];
          CFG_LRU_REFRESH: shadow_cfg.lru_refresh = cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
    fail_count   = n_fail;
    pending      = xlate_due.size();
    hit_count    = n_hit;
    miss_count   = n_miss;
    fault_count  = n_fault;
    bypass_count = n_bypass;
  end

endmodule

FILE: tb/tb_set_assoc_itlb_translate_core.sv
// ============================================================================
// tb_set_assoc_itlb_translate_core
// Stimulus and verdict for the set-associative instruction TLB.
// A short directed pass hits bypass, miss, hit, fault, peek and entry access,
// then phases of random traffic under different TLB settings: mostly entry
// installs followed by fetches into the installed page, plus stray lookups,
// entry accesses and unused opcodes. Checking lives in itlb_shadow_check.
// ============================================================================

module tb_set_assoc_itlb_translate_core;
  import saitlb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SETS         = 64;
  localparam int         MAX_WAYS     = 4;
  localparam int         NUM_PHASES   = 10;
  localparam int         RANDOM_ITEMS = 950;
  localparam int         LONG_HOLD    = 300;     // receiver hold-off, cycles
  localparam int         SETTLE       = 8;       // drain margin after last result
  localparam int         CYCLE_LIMIT  = 400_000;
  localparam logic [2:0] OP_SPARE_A   = 3'd6;    // opcodes with no function
  localparam logic [2:0] OP_SPARE_B   = 3'd7;
  localparam cfg_t       CFG_AT_RESET = '{1'b1, 3'd1, 3'd6, 5'd13, 2'd3};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [2:0]  in_opcode;
  logic [31:0] in_virt_addr;
  logic        in_mmu_on, in_supervisor;
  logic [1:0]  in_way_sel;
  logic [5:0]  in_set_sel;
  logic [31:0] in_write_word;
  logic        out_valid, out_ready;
  logic [31:0] out_phys_addr;
  logic [1:0]  out_status;
  logic        out_cache_inhibit;
  logic [31:0] out_read_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [4:0]  cfg_wdata;

  int   fail_count, pending, hit_count, miss_count, fault_count, bypass_count;
  int   n_sent;
  bit   quiet_tx, quiet_rx;   // no idling on that side while set
  bit   hold_req;             // asks the receiver for one long hold-off
  cfg_t cur_cfg;              // settings the stimulus aims its addresses at

  always #5 clk = ~clk;

  set_assoc_itlb_translate_core #(
    .SETS     (SETS),
    .MAX_WAYS (MAX_WAYS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_virt_addr      (in_virt_addr),
    .in_mmu_on         (in_mmu_on),
    .in_supervisor     (in_supervisor),
    .in_way_sel        (in_way_sel),
    .in_set_sel        (in_set_sel),
    .in_write_word     (in_write_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_phys_addr     (out_phys_addr),
    .out_status        (out_status),
    .out_cache_inhibit (out_cache_inhibit),
    .out_read_word     (out_read_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  itlb_shadow_check #(
    .SETS     (SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_virt_addr      (in_virt_addr),
    .in_mmu_on         (in_mmu_on),
    .in_supervisor     (in_supervisor),
    .in_way_sel        (in_way_sel),
    .in_set_sel        (in_set_sel),
    .in_write_word     (in_write_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_phys_addr     (out_phys_addr),
    .out_status        (out_status),
    .out_cache_inhibit (out_cache_inhibit),
    .out_read_word     (out_read_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .hit_count         (hit_count),
    .miss_count        (miss_count),
    .fault_count       (fault_count),
    .bypass_count      (bypass_count)
  );

  // --------------------------------------------------------------------------
  // Address helpers: page offset, tag bits and set number under cur_cfg.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] offset_mask();
    logic [63:0] wide;
    wide = (64'd1 << int'(cur_cfg.page_log2)) - 64'd1;
    return wide[31:0];
  endfunction

  function automatic logic [31:0] tag_mask();
    logic [63:0] wide;
    wide = ~((64'd1 << (int'(cur_cfg.page_log2) + int'(cur_cfg.sets_log2))) - 64'd1);
    return wide[31:0];
  endfunction

  // Sets beyond the store (seven set bits) fold onto a real set; the
  // lookup itself must then miss.
  function automatic logic [5:0] set_of(input logic [31:0] va);
    logic [31:0] s;
    s = (va >> cur_cfg.page_log2) & ((32'd1 << cur_cfg.sets_log2) - 32'd1);
    return s[5:0];
  endfunction

  function automatic req_t mk(input logic [2:0] op, input logic [31:0] va, input logic on,
                              input logic sup, input logic [1:0] way,
                              input logic [5:0] set_ix, input logic [31:0] word);
    return '{op, va, on, sup, way, set_ix, word};
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.opcode     = 3'($urandom_range(0, 7));
    r.virt_addr  = $urandom;
    r.mmu_on     = 1'($urandom_range(0, 1));
    r.supervisor = 1'($urandom_range(0, 1));
    r.way_sel    = 2'($urandom_range(0, 3));
    r.set_sel    = 6'($urandom_range(0, 63));
    r.write_word = $urandom;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Each call starts and ends on a falling edge. valid is
  // only lowered when a gap is drawn, so back-to-back requests keep it high.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t rq);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode     <= rq.opcode;
    in_virt_addr  <= rq.virt_addr;
    in_mmu_on     <= rq.mmu_on;
    in_supervisor <= rq.supervisor;
    in_way_sel    <= rq.way_sel;
    in_set_sel    <= rq.set_sel;
    in_write_word <= rq.write_word;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // Stop offering and wait for every outstanding result, plus a margin
  // for the row write-back.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [4:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic apply_cfg(input cfg_t c);
    cur_cfg = c;
    put_reg(CFG_MMU_PRESENT, 5'(c.mmu_present));
    put_reg(CFG_WAYS_IN_USE, 5'(c.ways_in_use));
    put_reg(CFG_SETS_LOG2,   5'(c.sets_log2));
    put_reg(CFG_PAGE_LOG2,   c.page_log2);
    put_reg(CFG_LRU_REFRESH, 5'(c.lru_refresh));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed pass at the reset settings (one way, 64 sets, 8 KiB pages).
  // --------------------------------------------------------------------------
  task automatic directed_pass();
    logic [31:0] va_a, tm;
    logic [5:0]  set_a;
    va_a  = 32'h1234_5678;
    tm    = tag_mask();
    set_a = set_of(va_a);
    // empty TLB: misses; MMU off: bypass with the upper-half CI rule
    send_req(mk(OP_TRANSLATE, 32'h0000_0000, 1'b1, 1'b1, 2'd0, 6'd0, 32'h0));
    send_req(mk(OP_PEEK,      32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 6'd0, 32'h0));
    send_req(mk(OP_TRANSLATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd3, 6'd63, 32'hFFFF_FFFF));
    send_req(mk(OP_PEEK,      32'h7FFF_FFFF, 1'b0, 1'b1, 2'd0, 6'd0, 32'h0));
    send_req(mk(OP_TRANSLATE, BYPASS_CI_LIMIT, 1'b0, 1'b1, 2'd0, 6'd0, 32'h0));
    // install a supervisor-only, cache-inhibited page with LRU at one
    send_req(mk(OP_WR_MATCH, 32'h0, 1'b0, 1'b0, 2'd0, set_a, (va_a & tm) | 32'h41));
    send_req(mk(OP_WR_TRANS, 32'h0, 1'b0, 1'b0, 2'd0, set_a,
                TR_PPN_MASK | 32'h82));
    send_req(mk(OP_TRANSLATE, va_a, 1'b1, 1'b1, 2'd0, 6'd0, 32'h0));  // hit
    send_req(mk(OP_TRANSLATE, va_a, 1'b1, 1'b0, 2'd0, 6'd0, 32'h0));  // user fault
    send_req(mk(OP_PEEK,      va_a, 1'b1, 1'b0, 2'd0, 6'd0, 32'h0));  // peek fault
    send_req(mk(OP_PEEK,      va_a, 1'b1, 1'b1, 2'd0, 6'd0, 32'h0));  // peek hit
    send_req(mk(OP_RD_MATCH,  32'h0, 1'b0, 1'b0, 2'd0, set_a, 32'h0));  // LRU after hits
    send_req(mk(OP_RD_TRANS,  32'h0, 1'b0, 1'b0, 2'd0, set_a, 32'h0));
    // extreme way/set and words
    send_req(mk(OP_WR_MATCH, 32'h0, 1'b0, 1'b0, 2'd3, 6'd63, 32'hFFFF_FFFF));
    send_req(mk(OP_WR_TRANS, 32'h0, 1'b0, 1'b0, 2'd3, 6'd63, 32'hFFFF_FFFF));
    send_req(mk(OP_RD_MATCH, 32'h0, 1'b0, 1'b0, 2'd3, 6'd63, 32'h0));
    send_req(mk(OP_RD_TRANS, 32'h0, 1'b0, 1'b0, 2'd3, 6'd63, 32'h0));
    send_req(mk(OP_WR_MATCH, 32'h0, 1'b0, 1'b0, 2'd0, 6'd0, 32'h0));
    send_req(mk(OP_RD_MATCH, 32'h0, 1'b0, 1'b0, 2'd0, 6'd0, 32'h0));
    // unused opcodes must return all zeros and leave the store alone
    send_req(mk(OP_SPARE_A, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 6'd63, 32'hFFFF_FFFF));
    send_req(mk(OP_SPARE_B, 32'h0, 1'b0, 1'b0, 2'd0, 6'd0, 32'h0));
    // same set, other tag: miss; then a user page at PPN zero
    send_req(mk(OP_TRANSLATE, va_a ^ 32'h8000_0000, 1'b1, 1'b1, 2'd0, 6'd0, 32'h0));
    send_req(mk(OP_WR_TRANS, 32'h0, 1'b0, 1'b0, 2'd0, set_a, 32'h0000_0040));
    send_req(mk(OP_TRANSLATE, va_a, 1'b1, 1'b0, 2'd0, 6'd0, 32'h0));
  endtask

  // --------------------------------------------------------------------------
  // One random burst. Mostly a well-formed install (match and translate
  // word for a page, sometimes in two ways) followed by fetches into that
  // page; the rest is stray lookups, stray entry access and unused opcodes.
  // --------------------------------------------------------------------------
  task automatic fetch_burst();
    req_t        rq;
    logic [31:0] va, om, tm;
    logic [1:0]  way;
    logic [5:0]  set_ix;
    int          kind, sel;
    kind   = $urandom_range(0, 99);
    va     = $urandom;
    om     = offset_mask();
    tm     = tag_mask();
    set_ix = set_of(va);
    if (kind < 60) begin
      repeat ($urandom_range(1, 2)) begin
        way = $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(0, 3));
        rq            = rand_req();
        rq.opcode     = OP_WR_MATCH;
        rq.way_sel    = way;
        rq.set_sel    = set_ix;
        rq.write_word = (va & tm) | (rq.write_word & ~tm) | 32'h1;
        if ($urandom_range(0, 9) == 0) rq.write_word[MR_VALID_BIT] = 1'b0;
        send_req(rq);
        rq         = rand_req();
        rq.opcode  = OP_WR_TRANS;
        rq.way_sel = way;
        rq.set_sel = set_ix;
        send_req(rq);
      end
      repeat ($urandom_range(1, 6)) begin
        rq  = rand_req();
        sel = $urandom_range(0, 19);
        if (sel < 12)      rq.opcode = OP_TRANSLATE;
        else if (sel < 17) rq.opcode = OP_PEEK;
        else if (sel < 19) rq.opcode = OP_RD_MATCH;
        else               rq.opcode = OP_RD_TRANS;
        if ($urandom_range(0, 7) != 0) rq.virt_addr = (va & ~om) | (rq.virt_addr & om);
        rq.mmu_on  = ($urandom_range(0, 9) != 0);
        rq.way_sel = way;
        rq.set_sel = set_ix;
        send_req(rq);
      end
    end else if (kind < 80) begin
      rq        = rand_req();
      rq.opcode = $urandom_range(0, 1) ? OP_TRANSLATE : OP_PEEK;
      rq.mmu_on = ($urandom_range(0, 4) != 0);
      send_req(rq);
    end else if (kind < 95) begin
      rq = rand_req();
      case ($urandom_range(0, 3))
        0:       rq.opcode = OP_WR_MATCH;
        1:       rq.opcode = OP_WR_TRANS;
        2:       rq.opcode = OP_RD_MATCH;
        default: rq.opcode = OP_RD_TRANS;
      endcase
      send_req(rq);
    end else begin
      rq        = rand_req();
      rq.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      send_req(rq);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each result, or the one long hold-off
  // when asked, during which the sender keeps pushing and the block backs up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = quiet_rx ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Hard stop well past the slowest legal run, clearing pass included.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** set_assoc_itlb_translate_core: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t phase_cfg [NUM_PHASES];
    int   target;
    bit   pressed, paused;
    // mmu_present, ways_in_use, sets_log2, page_log2, lru_refresh; includes
    // no ways searched, more ways than built, seven set bits (sets past the
    // store), a one-byte page, a 2 GiB page and the MMU left out
    phase_cfg = '{
      '{1'b1, 3'd4, 3'd6, 5'd10, 2'd3},
      '{1'b1, 3'd4, 3'd0, 5'd16, 2'd0},
      '{1'b1, 3'd2, 3'd3, 5'd12, 2'd1},
      '{1'b1, 3'd5, 3'd7, 5'd10, 2'd2},
      '{1'b1, 3'd0, 3'd5, 5'd13, 2'd3},
      '{1'b0, 3'd4, 3'd6, 5'd13, 2'd3},
      '{1'b1, 3'd3, 3'd2, 5'd0,  2'd1},
      '{1'b1, 3'd7, 3'd1, 5'd31, 2'd3},
      '{1'b1, 3'd4, 3'd6, 5'd16, 2'd2},
      '{1'b1, 3'd1, 3'd6, 5'd13, 2'd3}
    };
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_TRANSLATE;
    in_virt_addr  = '0;
    in_mmu_on     = 1'b0;
    in_supervisor = 1'b0;
    in_way_sel    = '0;
    in_set_sel    = '0;
    in_write_word = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MMU_PRESENT;
    cfg_wdata     = '0;
    cur_cfg       = CFG_AT_RESET;
    n_sent        = 0;
    pressed       = 1'b0;
    paused        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_pass();
    drain_all();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_cfg(phase_cfg[ph]);
      quiet_tx = (ph % 3 == 1);
      quiet_rx = (ph % 4 == 2);
      target   = n_sent + RANDOM_ITEMS / NUM_PHASES;
      while (n_sent < target) begin
        // back-pressure: sink holds off while requests keep coming
        if (ph == 1 && !pressed && n_sent > target - 60) begin
          hold_req = 1'b1;
          quiet_tx = 1'b1;
          pressed  = 1'b1;
        end
        // sender goes quiet until everything is back, mid-phase
        if (ph == 4 && !paused && n_sent > target - 50) begin
          drain_all();
          paused = 1'b1;
        end
        fetch_burst();
      end
      drain_all();
    end

    repeat (SETTLE) @(negedge clk);
    $display("Sent %0d requests across %0d TLB settings after a directed pass.",
             n_sent, NUM_PHASES);
    $display("Lookups seen: %0d hits, %0d misses, %0d faults, %0d bypassed.",
             hit_count, miss_count, fault_count, bypass_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** set_assoc_itlb_translate_core: PASSED **");
    end else begin
      $display("** set_assoc_itlb_translate_core: FAILED **");
    end
    $finish;
  end

endmodule
